@@ hdl/tbba_pkg.sv @@
// Shared types, codes and constants of the tagged block bump allocator.
`default_nettype none

package tbba_pkg;

   // Fixed field widths of the request and response transfers.
   localparam int ADDR_W   = 20;
   localparam int LEN_W    = 16;
   localparam int TAG_IN_W = 8;
   localparam int CAP_W    = 17;
   localparam int REFS_W   = 16;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   // Defaults for the top-level parameters.
   localparam int NUM_BLOCKS_DEF      = 16;
   localparam int MAX_BLOCK_BYTES_DEF = 65536;
   localparam int TAG_BITS_DEF        = 8;

   // Reset value of both capacity registers.
   localparam logic [CAP_W-1:0] CAP_RESET = 17'd4096;

   // Request modes.
   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRST_BLOCK_BYTES = 2'd0,
      CSR_LATER_BLOCK_BYTES = 2'd1
   } csr_index_type;

   // Response status codes.
   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOC    = 3'd0,
      ST_RELEASED = 3'd1,
      ST_EMPTIED  = 3'd2,
      ST_IGNORED  = 3'd3,
      ST_NO_SLOT  = 3'd4,
      ST_TOO_LONG = 3'd5
   } status_type;

   // Request payload.
   typedef struct packed {
      logic                mode;
      logic [LEN_W-1:0]    length;
      logic [TAG_IN_W-1:0] tag;
      logic [ADDR_W-1:0]   address;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/tagged_block_bump_allocator.sv @@
// A request is taken when start is high and busy is low. The block then walks its table of open
// blocks one entry per cycle through the single read port of the block RAM, using one shared
// tag/fill compare (allocate) or address range compare (free), and finishes with one update
// state, S_UPDATE on a hit or S_DECIDE otherwise; at most NUM_BLOCKS open blocks are visited.
// The result appears on rsp_payload for exactly one cycle with rsp_valid high, in the cycle
// after the update; the receiver cannot stall it, and busy is already low in that cycle. There
// is no clearing pass after reset. Configuration writes are always accepted and must only be
// issued while idle.
`default_nettype none

module tagged_block_bump_allocator
   import tbba_pkg::*;
#(
   parameter int NUM_BLOCKS      = NUM_BLOCKS_DEF,
   parameter int MAX_BLOCK_BYTES = MAX_BLOCK_BYTES_DEF,
   parameter int TAG_BITS        = TAG_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire req_type              req_payload,
   output logic                      rsp_valid,
   output rsp_type                   rsp_payload,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CAP_W-1:0]     csr_wdata
);

   localparam int IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
   localparam int FLAT_W  = $clog2(NUM_BLOCKS * MAX_BLOCK_BYTES) + 1;
   localparam int BASE_W  = (FLAT_W > ADDR_W + 1) ? FLAT_W : ADDR_W + 1;
   localparam int ENTRY_W = TAG_BITS + CAP_W + REFS_W;
   localparam logic [CAP_W-1:0]  MAX_CAP   = CAP_W'(MAX_BLOCK_BYTES);
   localparam logic [BASE_W-1:0] BASE_STEP = BASE_W'(MAX_BLOCK_BYTES);
   localparam logic [CNT_W-1:0]  NUM_CNT   = CNT_W'(NUM_BLOCKS);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_SCAN   = 4'b0010,
      S_UPDATE = 4'b0100,
      S_DECIDE = 4'b1000
   } state_type;

   state_type           state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [CNT_W-1:0]    open_ff, open_in;
   req_type             req_ff, req_in;
   logic [ENTRY_W-1:0]  hit_entry_ff, hit_entry_in;
   logic [CAP_W-1:0]    new_fill_ff, new_fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic [CAP_W-1:0]    first_cap_ff, later_cap_ff;

   logic                accept;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   logic [ENTRY_W-1:0]  wr_data;
   logic [ENTRY_W-1:0]  rd_data;

   logic [TAG_BITS+TAG_IN_W-1:0] tag_wide;
   logic [TAG_BITS-1:0] tag_eff;
   logic [CAP_W-1:0]    need;
   logic [TAG_BITS-1:0] ent_tag;
   logic [CAP_W-1:0]    ent_fill;
   logic [REFS_W-1:0]   ent_refs;
   logic [CAP_W:0]      fit_sum;
   logic [CAP_W-1:0]    scan_cap, new_cap;
   logic [BASE_W-1:0]   addr_ext, addr_diff;
   logic                last_entry;
   logic                scan_hit;
   logic [REFS_W-1:0]   hit_refs;
   logic [CAP_W-1:0]    hit_fill;
   logic [TAG_BITS-1:0] hit_tag;
   logic [REFS_W-1:0]   refs_dec;
   logic [BASE_W-1:0]   flat_addr;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_cap_ff <= CAP_RESET;
         later_cap_ff <= CAP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FIRST_BLOCK_BYTES: first_cap_ff <= csr_wdata;
            CSR_LATER_BLOCK_BYTES: later_cap_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Request fields as seen by the compare unit.
   always_comb begin
      tag_wide = {{TAG_BITS{1'b0}}, req_ff.tag};
      tag_eff  = tag_wide[TAG_BITS-1:0];
      need     = {1'b0, req_ff.length} + CAP_W'(1);
   end

   // Capacities clamped to the slot size of the flat address space.
   always_comb begin
      scan_cap = (idx_ff == '0) ? first_cap_ff : later_cap_ff;
      if (scan_cap > MAX_CAP) begin
         scan_cap = MAX_CAP;
      end
      new_cap = (open_ff == '0) ? first_cap_ff : later_cap_ff;
      if (new_cap > MAX_CAP) begin
         new_cap = MAX_CAP;
      end
   end

   // Shared compare unit: one table entry per cycle.
   always_comb begin
      ent_refs  = rd_data[REFS_W-1:0];
      ent_fill  = rd_data[REFS_W+CAP_W-1:REFS_W];
      ent_tag   = rd_data[ENTRY_W-1:REFS_W+CAP_W];
      fit_sum   = {1'b0, ent_fill} + {1'b0, need};
      addr_ext  = BASE_W'(req_ff.address);
      addr_diff = addr_ext - base_ff;
      if (req_ff.mode == MODE_ALLOC) begin
         scan_hit = (ent_tag == tag_eff) && (fit_sum <= {1'b0, scan_cap});
      end else begin
         scan_hit = (addr_ext >= base_ff) && (addr_diff < BASE_W'(ent_fill));
      end
      last_entry = ((CNT_W'(idx_ff) + CNT_W'(1)) == open_ff);
   end

   // Fields of the entry that matched.
   always_comb begin
      hit_refs  = hit_entry_ff[REFS_W-1:0];
      hit_fill  = hit_entry_ff[REFS_W+CAP_W-1:REFS_W];
      hit_tag   = hit_entry_ff[ENTRY_W-1:REFS_W+CAP_W];
      refs_dec  = (hit_refs != '0) ? hit_refs - REFS_W'(1) : '0;
      flat_addr = base_ff + BASE_W'(hit_fill);
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      base_in      = base_ff;
      open_in      = open_ff;
      req_in       = req_ff;
      hit_entry_in = hit_entry_ff;
      new_fill_in  = new_fill_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = hit_entry_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in   = req_payload;
               idx_in   = '0;
               base_in  = '0;
               state_in = (open_ff == '0) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_hit) begin
               hit_entry_in = rd_data;
               new_fill_in  = fit_sum[CAP_W-1:0];
               state_in     = S_UPDATE;
            end else begin
               base_in = base_ff + BASE_STEP;
               if (last_entry) begin
                  state_in = S_DECIDE;
               end else begin
                  idx_in = idx_ff + IDX_W'(1);
               end
            end
         end
         S_UPDATE: begin
            wr_en        = 1'b1;
            rsp_valid_in = 1'b1;
            rsp_in.addr  = '0;
            if (req_ff.mode == MODE_ALLOC) begin
               wr_data = {hit_tag, new_fill_ff,
                          (hit_refs != '1) ? hit_refs + REFS_W'(1) : hit_refs};
               rsp_in.addr   = flat_addr[ADDR_W-1:0];
               rsp_in.status = ST_ALLOC;
            end else if (refs_dec != '0) begin
               wr_data       = {hit_tag, hit_fill, refs_dec};
               rsp_in.status = ST_RELEASED;
            end else begin
               wr_data       = {hit_tag, {CAP_W{1'b0}}, {REFS_W{1'b0}}};
               rsp_in.status = ST_EMPTIED;
            end
            state_in = S_IDLE;
         end
         S_DECIDE: begin
            rsp_valid_in = 1'b1;
            rsp_in.addr  = '0;
            wr_addr      = open_ff[IDX_W-1:0];
            wr_data      = {tag_eff, need, REFS_W'(1)};
            if (req_ff.mode == MODE_FREE) begin
               rsp_in.status = ST_IGNORED;
            end else if (open_ff >= NUM_CNT) begin
               rsp_in.status = ST_NO_SLOT;
            end else if (need > new_cap) begin
               rsp_in.status = ST_TOO_LONG;
            end else begin
               // Open the next block with the request's tag.
               wr_en         = 1'b1;
               open_in       = open_ff + CNT_W'(1);
               rsp_in.addr   = base_ff[ADDR_W-1:0];
               rsp_in.status = ST_ALLOC;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      base_ff      <= base_in;
      req_ff       <= req_in;
      hit_entry_ff <= hit_entry_in;
      new_fill_ff  <= new_fill_in;
      rsp_ff       <= rsp_in;
   end

   // Block table: tag, fill and reference count per slot.
   tbba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_BLOCKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

`ifndef NO_ASSERTIONS
   // Every finishing state produces exactly one response strobe.
   a_rsp_after_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE || state_ff == S_DECIDE) |=> rsp_valid)
      else $error("missing response after finishing a request");

   // A response strobe only follows a finishing state.
   a_rsp_only_after_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(reset)) |->
         ($past(state_ff) == S_UPDATE || $past(state_ff) == S_DECIDE))
      else $error("response strobe without a finished request");

   // The count of open blocks never exceeds the table and only grows by one.
   a_open_bounded: assert property (@(posedge clock) disable iff (reset)
      open_ff <= NUM_CNT)
      else $error("open block count beyond table depth");

   a_open_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && open_ff != $past(open_ff)) |->
         (open_ff == $past(open_ff) + CNT_W'(1) && $past(state_ff) == S_DECIDE))
      else $error("open block count changed unexpectedly");

   // An accepted request makes the block busy in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("request accepted but block not busy");
`endif

endmodule

`default_nettype wire

@@ hdl/tbba_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module tbba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                      clock,
   input  wire logic                                      wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                          wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

@@ sim/tagged_block_bump_allocator_tb.sv @@
// Self-checking testbench for the tagged block bump allocator: directed table, random phases.
`timescale 1ns / 100ps

module tagged_block_bump_allocator_tb;
   import tbba_pkg::*;

   localparam int NUM_SLOTS = NUM_BLOCKS_DEF;
   localparam int MAX_BYTES = MAX_BLOCK_BYTES_DEF;

   // One row of the directed table: either a register write or a request.
   typedef struct {
      bit                is_csr;
      csr_index_type     csr_idx;
      logic [CAP_W-1:0]  csr_val;
      req_type           req;
      bit                typed;
      rsp_type           want;
   } dir_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   req_type              req_payload = '0;
   logic                 rsp_valid;
   rsp_type              rsp_payload;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = CSR_FIRST_BLOCK_BYTES;
   logic [CAP_W-1:0]     csr_wdata = '0;

   // Predicted allocator state and configuration.
   int unsigned          first_cap;
   int unsigned          later_cap;
   int unsigned          slots_open;
   logic [TAG_IN_W-1:0]  slot_tag [NUM_SLOTS];
   int unsigned          slot_fill [NUM_SLOTS];
   int unsigned          slot_refs [NUM_SLOTS];

   rsp_type              pending_rsps [$];
   int unsigned          live_addrs [$];
   dir_row_type          dir_rows [$];
   logic [TAG_IN_W-1:0]  tag_pool [4];
   int                   mismatches = 0;
   int                   burst_left = 0;

   tagged_block_bump_allocator u_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Effective capacity of a slot; values above the block size are clipped.
   function automatic int unsigned slot_cap(int unsigned slot);
      int unsigned c;
      c = (slot == 0) ? first_cap : later_cap;
      return (c > MAX_BYTES) ? MAX_BYTES : c;
   endfunction

   // Computes the response to one request and advances the predicted state.
   function automatic rsp_type allocator_response(req_type r);
      rsp_type     res;
      int unsigned need;
      int unsigned base;
      int unsigned i;
      res = '0;
      need = int'(r.length) + 1;
      if (r.mode == MODE_ALLOC) begin
         // Lowest open slot with the same tag and enough room wins.
         for (i = 0; i < slots_open; i++) begin
            if (slot_tag[i] == r.tag && slot_fill[i] + need <= slot_cap(i)) begin
               res.addr   = ADDR_W'(i * MAX_BYTES + slot_fill[i]);
               res.status = ST_ALLOC;
               slot_fill[i] += need;
               if (slot_refs[i] < 32'hFFFF) slot_refs[i]++;
               return res;
            end
         end
         // Otherwise open the next slot, if there is one and the string fits.
         if (slots_open >= NUM_SLOTS) begin
            res.status = ST_NO_SLOT;
         end else if (need > slot_cap(slots_open)) begin
            res.status = ST_TOO_LONG;
         end else begin
            slot_tag[slots_open]  = r.tag;
            slot_fill[slots_open] = need;
            slot_refs[slots_open] = 1;
            res.addr   = ADDR_W'(slots_open * MAX_BYTES);
            res.status = ST_ALLOC;
            slots_open++;
         end
         return res;
      end
      // A free goes to the open slot whose used range holds the address.
      for (i = 0; i < slots_open; i++) begin
         base = i * MAX_BYTES;
         if (int'(r.address) >= base && int'(r.address) - base < slot_fill[i]) begin
            if (slot_refs[i] > 0) slot_refs[i]--;
            if (slot_refs[i] != 0) begin
               res.status = ST_RELEASED;
            end else begin
               slot_fill[i] = 0;
               res.status   = ST_EMPTIED;
            end
            return res;
         end
      end
      res.status = ST_IGNORED;
      return res;
   endfunction

   // Table helpers for the directed part.
   function automatic void dir_req(logic mode, int unsigned len, int unsigned tag,
                                   int unsigned address, bit typed, status_type st,
                                   int unsigned addr);
      dir_row_type row;
      row = '{csr_idx: CSR_FIRST_BLOCK_BYTES, default: '0};
      row.req.mode    = mode;
      row.req.length  = LEN_W'(len);
      row.req.tag     = TAG_IN_W'(tag);
      row.req.address = ADDR_W'(address);
      row.typed       = typed;
      row.want.status = st;
      row.want.addr   = ADDR_W'(addr);
      dir_rows.push_back(row);
   endfunction

   function automatic void dir_csr(csr_index_type idx, int unsigned val);
      dir_row_type row;
      row = '{csr_idx: CSR_FIRST_BLOCK_BYTES, default: '0};
      row.is_csr  = 1'b1;
      row.csr_idx = idx;
      row.csr_val = CAP_W'(val);
      dir_rows.push_back(row);
   endfunction

   // Presents one request and waits for its transfer; records the expected response.
   task automatic send_request(req_type r, bit typed, rsp_type want);
      rsp_type predicted;
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
      predicted = allocator_response(r);
      if (predicted.status == ST_ALLOC) live_addrs.push_back(predicted.addr);
      pending_rsps.push_back(typed ? want : predicted);
   endtask

   // Bursts of random length with random gaps, sometimes long stretches without gaps.
   task automatic pace_sender();
      int unsigned gap;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 100 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Lowers start and waits until every expected response has arrived.
   task automatic wait_idle();
      start <= 1'b0;
      while (pending_rsps.size() != 0 || busy) @(posedge clock);
   endtask

   // Register write over the configuration channel, only while idle.
   task automatic write_csr(csr_index_type idx, logic [CAP_W-1:0] val);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FIRST_BLOCK_BYTES) first_cap = val;
      else later_cap = val;
   endtask

   // Random request: mostly allocations from a small tag pool and frees of live strings.
   function automatic req_type make_request();
      req_type     r;
      int unsigned pick;
      r         = '0;
      r.address = ADDR_W'($urandom);
      r.tag     = ($urandom_range(0, 6) == 0) ? TAG_IN_W'($urandom)
                                              : tag_pool[$urandom_range(0, 3)];
      case ($urandom_range(0, 9))
         0:       r.length = '0;
         1, 2, 3: r.length = LEN_W'($urandom_range(0, 15));
         4, 5:    r.length = LEN_W'($urandom_range(0, 255));
         6:       r.length = LEN_W'($urandom_range(0, 4095));
         7:       r.length = LEN_W'($urandom_range(60000, 65535));
         default: r.length = LEN_W'($urandom);
      endcase
      if ($urandom_range(0, 99) < 45) begin
         r.mode = MODE_FREE;
         pick = $urandom_range(0, 9);
         if (pick < 7 && live_addrs.size() != 0) begin
            pick = $urandom_range(0, live_addrs.size() - 1);
            r.address = ADDR_W'(live_addrs[pick]);
            live_addrs.delete(pick);
         end else if (pick < 9) begin
            r.address = ADDR_W'($urandom_range(0, NUM_SLOTS - 1) * MAX_BYTES
                                + $urandom_range(0, 63));
         end
      end else begin
         r.mode = MODE_ALLOC;
      end
      return r;
   endfunction

   // Response checker: each transfer is compared with the oldest expectation.
   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_rsps.size() == 0) begin
            $error("unexpected response: addr %h status %0d",
                   rsp_payload.addr, rsp_payload.status);
            mismatches++;
         end else begin
            want = pending_rsps.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_payload.status);
               mismatches++;
            end
            if (rsp_payload.addr !== want.addr) begin
               $error("addr: expected %h, actual %h", want.addr, rsp_payload.addr);
               mismatches++;
            end
         end
      end
   end

   // Stimulus.
   initial begin : stimulus
      int unsigned n;
      int unsigned p;
      int unsigned fcap;
      int unsigned lcap;

      first_cap  = CAP_RESET;
      later_cap  = CAP_RESET;
      slots_open = 0;
      foreach (tag_pool[k]) tag_pool[k] = TAG_IN_W'($urandom);

      // Directed table: reset defaults, extremes of every field, each corner case.
      dir_req(MODE_FREE,  0,      8'h00, 20'h00000, 1, ST_IGNORED,  0);
      dir_req(MODE_ALLOC, 0,      8'h00, 20'hFFFFF, 1, ST_ALLOC,    20'h00000);
      dir_req(MODE_ALLOC, 65535,  8'hFF, 20'h00000, 1, ST_TOO_LONG, 0);
      dir_req(MODE_ALLOC, 4095,   8'hFF, 20'h00000, 1, ST_ALLOC,    20'h10000);
      dir_req(MODE_ALLOC, 0,      8'hFF, 20'h00000, 1, ST_ALLOC,    20'h20000);
      dir_req(MODE_ALLOC, 10,     8'h00, 20'h00000, 1, ST_ALLOC,    20'h00001);
      dir_req(MODE_FREE,  0,      8'h00, 20'h10000, 1, ST_EMPTIED,  0);
      dir_req(MODE_FREE,  65535,  8'hFF, 20'h00005, 1, ST_RELEASED, 0);
      dir_req(MODE_FREE,  0,      8'h00, 20'h0000B, 1, ST_EMPTIED,  0);
      dir_req(MODE_FREE,  0,      8'h00, 20'h00000, 1, ST_IGNORED,  0);
      dir_req(MODE_FREE,  0,      8'h00, 20'hFFFFF, 1, ST_IGNORED,  0);
      // Zero capacity for later slots: opening one cannot succeed.
      dir_csr(CSR_LATER_BLOCK_BYTES, 0);
      dir_req(MODE_ALLOC, 0,      8'h5A, 20'h00000, 1, ST_TOO_LONG, 0);
      dir_req(MODE_ALLOC, 0,      8'h00, 20'h00000, 1, ST_ALLOC,    20'h00000);
      dir_req(MODE_ALLOC, 0,      8'hFF, 20'h00000, 1, ST_TOO_LONG, 0);
      // Capacity above the block size is clipped to a full block.
      dir_csr(CSR_LATER_BLOCK_BYTES, 17'h1FFFF);
      dir_req(MODE_ALLOC, 65535,  8'hFF, 20'h00000, 1, ST_ALLOC,    20'h10000);
      // First slot lowered to its fill no longer takes anything.
      dir_csr(CSR_FIRST_BLOCK_BYTES, 1);
      dir_req(MODE_ALLOC, 0,      8'h00, 20'h00000, 1, ST_ALLOC,    20'h30000);
      dir_req(MODE_FREE,  0,      8'h00, 20'h30000, 1, ST_EMPTIED,  0);
      dir_req(MODE_FREE,  0,      8'h00, 20'h1FFFF, 1, ST_EMPTIED,  0);
      dir_req(MODE_ALLOC, 16'h00FF, 8'hA5, 20'h00000, 1, ST_ALLOC,  20'h40000);
      dir_req(MODE_ALLOC, 16'hFF00, 8'hA5, 20'h00000, 1, ST_ALLOC,  20'h50000);
      dir_req(MODE_FREE,  0,      8'h00, 20'h000FF, 0, ST_ALLOC,    0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            write_csr(dir_rows[i].csr_idx, dir_rows[i].csr_val);
         end else begin
            send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
            pace_sender();
         end
      end

      // Random phases over several capacity settings, extremes among them.
      for (p = 0; p < 7; p++) begin
         case (p)
            0:       begin fcap = 4096;     lcap = 4096;     end
            1:       begin fcap = 1;        lcap = 1;        end
            2:       begin fcap = 65536;    lcap = 65536;    end
            3:       begin fcap = 17'h1FFFF; lcap = 100;     end
            4:       begin fcap = 0;        lcap = 512;      end
            5:       begin fcap = 300;      lcap = 17'h1FFFF; end
            default: begin
               fcap = $urandom_range(1, 65536);
               lcap = $urandom_range(1, 65536);
            end
         endcase
         write_csr(CSR_FIRST_BLOCK_BYTES, CAP_W'(fcap));
         write_csr(CSR_LATER_BLOCK_BYTES, CAP_W'(lcap));
         repeat (260) begin
            send_request(make_request(), 1'b0, '0);
            pace_sender();
         end
      end

      // Drain outstanding responses, then let the block settle.
      start <= 1'b0;
      n = 0;
      while (pending_rsps.size() != 0 && n < 2000) begin
         @(posedge clock);
         n++;
      end
      repeat (20) @(posedge clock);
      if (pending_rsps.size() != 0) begin
         $error("%0d expected responses never arrived", pending_rsps.size());
         mismatches++;
      end

      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #200_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
